[src/batch_norm_inference_fp32_core_defines.svh]
`ifndef BATCH_NORM_INFERENCE_FP32_CORE_DEFINES_SVH
`define BATCH_NORM_INFERENCE_FP32_CORE_DEFINES_SVH

// Assertion helpers sampled on i_clk and disabled while i_rst_n is low.
`define BNIF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BNIF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/bnif_pkg.sv]
`default_nettype none

package bnif_pkg;

    localparam logic [31:0] FpQnan   = 32'h7FC0_0000;
    localparam logic [31:0] FpInf    = 32'h7F80_0000;
    localparam logic [31:0] FpOne    = 32'h3F80_0000;
    localparam logic [31:0] EpsReset = 32'h3727_C5AC;

    typedef logic signed [11:0] t_exp;

    typedef enum logic [1:0] {
        CFG_EPSILON    = 2'd0,
        CFG_USE_WEIGHT = 2'd1,
        CFG_USE_BIAS   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_MUL,
        OP_SQRT,
        OP_RECIP,
        OP_FMA
    } t_fp_op;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_MUL,
        FS_UNORM,
        FS_SQRT,
        FS_DIV,
        FS_PRENORM,
        FS_SWAP,
        FS_ALIGN,
        FS_SUM,
        FS_NORM,
        FS_DENORM,
        FS_ROUND,
        FS_DONE
    } t_fpu_state;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_ADDV,
        CS_SQRT,
        CS_RECIP,
        CS_MULW,
        CS_MULM,
        CS_ADDB,
        CS_FMA,
        CS_OUT
    } t_ctl_state;

    typedef struct packed {
        logic        start;
        t_fp_op      op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_fpu_rsp;

    function automatic logic is_nan(input logic [31:0] x);
        return x[30:0] > FpInf[30:0];
    endfunction

    function automatic logic is_inf(input logic [31:0] x);
        return x[30:0] == FpInf[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic t_exp unpack_exp(input logic [31:0] x);
        t_exp e;
        if (x[30:23] == 8'd0) begin
            e = t_exp'(-149);
        end else begin
            e = t_exp'({4'd0, x[30:23]}) - t_exp'(150);
        end
        return e;
    endfunction

    function automatic logic [23:0] unpack_man(input logic [31:0] x);
        return {(x[30:23] != 8'd0), x[22:0]};
    endfunction

endpackage

`default_nettype wire

[src/bnif_fpu.sv]
`default_nettype none

module bnif_fpu (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  bnif_pkg::t_fpu_req i_req,
    output bnif_pkg::t_fpu_rsp o_rsp
);
    import bnif_pkg::*;

    t_fpu_state  r_state, n_state;
    t_fp_op      r_op, n_op;
    logic        r_sa, n_sa, r_sb, n_sb, r_sc, n_sc;
    t_exp        r_ea, n_ea, r_eb, n_eb, r_ec, n_ec;
    logic [63:0] r_ma, n_ma, r_mb, n_mb;
    logic [23:0] r_mc, n_mc;
    logic [23:0] r_rem, n_rem;
    logic        r_stk, n_stk;
    logic        r_czero, n_czero;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_res, n_res;

    logic        spec_hit;
    logic [31:0] spec_val;
    logic        ps;

    logic [63:0] sq_bit, sq_t, sq_v_next, sq_r_next;
    logic [64:0] sq_diff;
    logic        sq_ge, sq_odd;
    logic [24:0] sq_m;
    t_exp        sq_e;
    logic [24:0] dv_sh;
    logic [25:0] dv_diff;
    logic        dv_ge;
    logic [23:0] dv_rem_next;
    logic [23:0] rd_kept;
    logic        rd_up;
    t_exp        rd_bexp;
    logic [31:0] rd_bits;
    t_exp        big_e;
    logic [63:0] sum;
    logic [47:0] prod;

    always_comb begin
        spec_hit = 1'b1;
        spec_val = FpQnan;
        ps       = i_req.a[31] ^ i_req.b[31];
        case (i_req.op)
            OP_ADD: begin
                if (is_nan(i_req.a) || is_nan(i_req.b)) begin
                    spec_val = FpQnan;
                end else if (is_inf(i_req.a) && is_inf(i_req.b)) begin
                    spec_val = (i_req.a[31] == i_req.b[31]) ? i_req.a : FpQnan;
                end else if (is_inf(i_req.a)) begin
                    spec_val = i_req.a;
                end else if (is_inf(i_req.b)) begin
                    spec_val = i_req.b;
                end else if (is_zero(i_req.a) && is_zero(i_req.b)) begin
                    spec_val = {i_req.a[31] & i_req.b[31], 31'd0};
                end else if (is_zero(i_req.a)) begin
                    spec_val = i_req.b;
                end else if (is_zero(i_req.b)) begin
                    spec_val = i_req.a;
                end else begin
                    spec_hit = 1'b0;
                end
            end
            OP_MUL: begin
                if (is_nan(i_req.a) || is_nan(i_req.b)) begin
                    spec_val = FpQnan;
                end else if (is_inf(i_req.a) || is_inf(i_req.b)) begin
                    spec_val = (is_zero(i_req.a) || is_zero(i_req.b)) ? FpQnan
                                                                     : {ps, FpInf[30:0]};
                end else if (is_zero(i_req.a) || is_zero(i_req.b)) begin
                    spec_val = {ps, 31'd0};
                end else begin
                    spec_hit = 1'b0;
                end
            end
            OP_SQRT: begin
                if (is_nan(i_req.a)) begin
                    spec_val = FpQnan;
                end else if (is_zero(i_req.a)) begin
                    spec_val = i_req.a;
                end else if (i_req.a[31]) begin
                    spec_val = FpQnan;
                end else if (is_inf(i_req.a)) begin
                    spec_val = i_req.a;
                end else begin
                    spec_hit = 1'b0;
                end
            end
            OP_RECIP: begin
                if (is_nan(i_req.a)) begin
                    spec_val = FpQnan;
                end else if (is_inf(i_req.a)) begin
                    spec_val = {i_req.a[31], 31'd0};
                end else if (is_zero(i_req.a)) begin
                    spec_val = {i_req.a[31], FpInf[30:0]};
                end else begin
                    spec_hit = 1'b0;
                end
            end
            OP_FMA: begin
                if (is_nan(i_req.a) || is_nan(i_req.b) || is_nan(i_req.c)) begin
                    spec_val = FpQnan;
                end else if (is_inf(i_req.a) || is_inf(i_req.b)) begin
                    if (is_zero(i_req.a) || is_zero(i_req.b)) begin
                        spec_val = FpQnan;
                    end else if (is_inf(i_req.c) && (i_req.c[31] != ps)) begin
                        spec_val = FpQnan;
                    end else begin
                        spec_val = {ps, FpInf[30:0]};
                    end
                end else if (is_inf(i_req.c)) begin
                    spec_val = i_req.c;
                end else if (is_zero(i_req.a) || is_zero(i_req.b)) begin
                    spec_val = is_zero(i_req.c) ? {ps & i_req.c[31], 31'd0} : i_req.c;
                end else begin
                    spec_hit = 1'b0;
                end
            end
            default: begin
                spec_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        sq_bit    = 64'd1 << {r_cnt[4:0], 1'b0};
        sq_t      = r_mb | sq_bit;
        sq_diff   = {1'b0, r_ma} - {1'b0, sq_t};
        sq_ge     = !sq_diff[64];
        sq_v_next = sq_ge ? sq_diff[63:0] : r_ma;
        sq_r_next = sq_ge ? ((r_mb >> 1) + sq_bit) : (r_mb >> 1);
        sq_odd    = r_ea[0];
        sq_m      = sq_odd ? {r_ma[23:0], 1'b0} : {1'b0, r_ma[23:0]};
        sq_e      = r_ea - (sq_odd ? t_exp'(39) : t_exp'(38));

        dv_sh       = {r_rem, 1'b0};
        dv_diff     = {1'b0, dv_sh} - {2'd0, r_mb[23:0]};
        dv_ge       = !dv_diff[25];
        dv_rem_next = dv_ge ? dv_diff[23:0] : dv_sh[23:0];

        rd_kept = r_ma[62:39];
        rd_up   = r_ma[38] & ((|r_ma[37:0]) | r_stk | rd_kept[0]);
        rd_bexp = r_ea + t_exp'(188);
        rd_bits = {1'b0, rd_bexp[7:0], 23'd0} + {8'd0, rd_kept} + {31'd0, rd_up};

        big_e = r_ea + t_exp'(62);
        sum   = (r_sa == r_sb) ? (r_ma + r_mb) : (r_ma - r_mb - {63'd0, r_stk});
        prod  = r_ma[23:0] * r_mb[23:0];
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_sa    = r_sa;
        n_sb    = r_sb;
        n_sc    = r_sc;
        n_ea    = r_ea;
        n_eb    = r_eb;
        n_ec    = r_ec;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_mc    = r_mc;
        n_rem   = r_rem;
        n_stk   = r_stk;
        n_czero = r_czero;
        n_cnt   = r_cnt;
        n_res   = r_res;
        case (r_state)
            FS_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_sa    = i_req.a[31];
                    n_ea    = unpack_exp(i_req.a);
                    n_ma    = {40'd0, unpack_man(i_req.a)};
                    n_sb    = i_req.b[31];
                    n_eb    = unpack_exp(i_req.b);
                    n_mb    = {40'd0, unpack_man(i_req.b)};
                    n_sc    = i_req.c[31];
                    n_ec    = unpack_exp(i_req.c);
                    n_mc    = unpack_man(i_req.c);
                    n_czero = is_zero(i_req.c);
                    n_stk   = 1'b0;
                    if (spec_hit) begin
                        n_res   = spec_val;
                        n_state = FS_DONE;
                    end else begin
                        case (i_req.op)
                            OP_ADD:            n_state = FS_PRENORM;
                            OP_MUL, OP_FMA:    n_state = FS_MUL;
                            OP_SQRT, OP_RECIP: n_state = FS_UNORM;
                            default:           n_state = FS_IDLE;
                        endcase
                    end
                end
            end
            FS_MUL: begin
                n_ma = {16'd0, prod};
                n_ea = r_ea + r_eb;
                n_sa = r_sa ^ r_sb;
                if ((r_op == OP_FMA) && !r_czero) begin
                    n_sb    = r_sc;
                    n_eb    = r_ec;
                    n_mb    = {40'd0, r_mc};
                    n_state = FS_PRENORM;
                end else begin
                    n_state = FS_NORM;
                end
            end
            FS_UNORM: begin
                if (!r_ma[23]) begin
                    n_ma = r_ma << 1;
                    n_ea = r_ea - t_exp'(1);
                end else if (r_op == OP_SQRT) begin
                    n_ma    = {1'b0, sq_m, 38'd0};
                    n_ea    = sq_e >>> 1;
                    n_mb    = 64'd0;
                    n_cnt   = 6'd31;
                    n_state = FS_SQRT;
                end else begin
                    n_mb    = {40'd0, r_ma[23:0]};
                    n_ea    = t_exp'(-63) - r_ea;
                    n_ma    = {63'd0, (r_ma[23:0] == 24'h80_0000)};
                    n_rem   = (r_ma[23:0] == 24'h80_0000) ? 24'd0 : 24'h80_0000;
                    n_cnt   = 6'd39;
                    n_state = FS_DIV;
                end
            end
            FS_SQRT: begin
                n_ma  = sq_v_next;
                n_mb  = sq_r_next;
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_ma    = sq_r_next;
                    n_stk   = (sq_v_next != 64'd0);
                    n_state = FS_NORM;
                end
            end
            FS_DIV: begin
                n_rem = dv_rem_next;
                n_ma  = {r_ma[62:0], dv_ge};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    n_stk   = (dv_rem_next != 24'd0);
                    n_state = FS_NORM;
                end
            end
            FS_PRENORM: begin
                if (r_ma[60:53] == 8'd0) begin
                    n_ma = r_ma << 8;
                    n_ea = r_ea - t_exp'(8);
                end else if (!r_ma[60]) begin
                    n_ma = r_ma << 1;
                    n_ea = r_ea - t_exp'(1);
                end
                if (r_mb[60:53] == 8'd0) begin
                    n_mb = r_mb << 8;
                    n_eb = r_eb - t_exp'(8);
                end else if (!r_mb[60]) begin
                    n_mb = r_mb << 1;
                    n_eb = r_eb - t_exp'(1);
                end
                if (r_ma[60] && r_mb[60]) begin
                    n_state = FS_SWAP;
                end
            end
            FS_SWAP: begin
                n_stk = 1'b0;
                if ((r_eb > r_ea) || ((r_eb == r_ea) && (r_mb > r_ma))) begin
                    n_sa = r_sb;
                    n_ea = r_eb;
                    n_ma = r_mb;
                    n_sb = r_sa;
                    n_eb = r_ea;
                    n_mb = r_ma;
                end
                n_state = FS_ALIGN;
            end
            FS_ALIGN: begin
                if ((r_eb == r_ea) || (r_mb == 64'd0)) begin
                    n_state = FS_SUM;
                end else if ((r_ea - r_eb) >= t_exp'(8)) begin
                    n_mb  = r_mb >> 8;
                    n_stk = r_stk | (|r_mb[7:0]);
                    n_eb  = r_eb + t_exp'(8);
                end else begin
                    n_mb  = r_mb >> 1;
                    n_stk = r_stk | r_mb[0];
                    n_eb  = r_eb + t_exp'(1);
                end
            end
            FS_SUM: begin
                if ((sum == 64'd0) && !r_stk) begin
                    n_res   = 32'd0;
                    n_state = FS_DONE;
                end else begin
                    n_ma    = sum;
                    n_state = FS_NORM;
                end
            end
            FS_NORM: begin
                if (r_ma[62:55] == 8'd0) begin
                    n_ma = r_ma << 8;
                    n_ea = r_ea - t_exp'(8);
                end else if (!r_ma[62]) begin
                    n_ma = r_ma << 1;
                    n_ea = r_ea - t_exp'(1);
                end else if (big_e > t_exp'(127)) begin
                    n_res   = {r_sa, FpInf[30:0]};
                    n_state = FS_DONE;
                end else if (big_e < t_exp'(-152)) begin
                    n_res   = {r_sa, 31'd0};
                    n_state = FS_DONE;
                end else if (big_e < t_exp'(-126)) begin
                    n_state = FS_DENORM;
                end else begin
                    n_state = FS_ROUND;
                end
            end
            FS_DENORM: begin
                n_ma  = r_ma >> 1;
                n_stk = r_stk | r_ma[0];
                n_ea  = r_ea + t_exp'(1);
                if ((r_ea + t_exp'(1)) == t_exp'(-188)) begin
                    n_state = FS_ROUND;
                end
            end
            FS_ROUND: begin
                n_res   = (rd_bits >= FpInf) ? {r_sa, FpInf[30:0]} : {r_sa, rd_bits[30:0]};
                n_state = FS_DONE;
            end
            FS_DONE: begin
                n_state = FS_IDLE;
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_sa    <= n_sa;
        r_sb    <= n_sb;
        r_sc    <= n_sc;
        r_ea    <= n_ea;
        r_eb    <= n_eb;
        r_ec    <= n_ec;
        r_ma    <= n_ma;
        r_mb    <= n_mb;
        r_mc    <= n_mc;
        r_rem   <= n_rem;
        r_stk   <= n_stk;
        r_czero <= n_czero;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
    end

    assign o_rsp.done   = (r_state == FS_DONE);
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

[src/batch_norm_inference_fp32_core.sv]
// Inference batch normalization on IEEE-754 single-precision values.
// Input channel: i_in_valid / o_in_stall with one beat per item. A beat with
// i_req_type low loads a channel: scale = w / sqrt(var + eps) and
// offset = b - mean * scale are computed and stored, and no result beat
// follows. A beat with i_req_type high normalizes i_sample_value as the fused
// scale * x + offset and produces one result beat on o_out_valid / i_out_stall,
// carrying i_last_sample through to o_last.
// All arithmetic runs on one shared floating-point unit: square root and
// divide retire one result bit per cycle, alignment and normalization shift
// by one or eight bits per cycle. A sample reaches its result beat soonest
// when scale or sample is zero or any operand is infinite or NaN, since the
// unit then returns a special value without iterating; otherwise its time
// depends on exponent spread, cancellation and subnormals. A channel load is
// quickest when every step meets such an operand.
// One item is in flight. The next item is accepted while a finished result
// waits in the output register; a stalled result holds until taken, and a
// finished sample then waits for the output register before the block
// accepts again.
// Reset clears scale and offset to +0.0, restores the register defaults and
// empties the output register. Registers are written through i_cfg_wr_en.
`default_nettype none
`include "batch_norm_inference_fp32_core_defines.svh"

module batch_norm_inference_fp32_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire [1:0]  i_cfg_index,
    input  wire [31:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire        i_req_type,
    input  wire [31:0] i_chan_weight,
    input  wire [31:0] i_chan_bias,
    input  wire [31:0] i_chan_mean,
    input  wire [31:0] i_chan_variance,
    input  wire [31:0] i_sample_value,
    input  wire        i_last_sample,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [31:0] o_normalized,
    output logic       o_last
);
    import bnif_pkg::*;

    t_ctl_state  r_state, n_state;
    logic        r_issued, n_issued;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_normalized, n_normalized;
    logic        r_last, n_last;
    logic [31:0] r_scale, n_scale;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_w, n_w;
    logic [31:0] r_bias, n_bias;
    logic [31:0] r_mean, n_mean;
    logic [31:0] r_var, n_var;
    logic [31:0] r_x, n_x;
    logic        r_item_last, n_item_last;
    logic [31:0] r_tmp, n_tmp;
    logic [31:0] r_eps;
    logic        r_use_w;
    logic        r_use_b;

    t_fpu_req    fpu_req;
    t_fpu_rsp    fpu_rsp;

    bnif_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps   <= EpsReset;
            r_use_w <= 1'b1;
            r_use_b <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_EPSILON:    r_eps   <= i_cfg_data;
                CFG_USE_WEIGHT: r_use_w <= i_cfg_data[0];
                CFG_USE_BIAS:   r_use_b <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_issued     = r_issued;
        n_out_valid  = r_out_valid;
        n_normalized = r_normalized;
        n_last       = r_last;
        n_scale      = r_scale;
        n_offset     = r_offset;
        n_w          = r_w;
        n_bias       = r_bias;
        n_mean       = r_mean;
        n_var        = r_var;
        n_x          = r_x;
        n_item_last  = r_item_last;
        n_tmp        = r_tmp;
        fpu_req.start = 1'b0;
        fpu_req.op    = OP_ADD;
        fpu_req.a     = r_tmp;
        fpu_req.b     = r_tmp;
        fpu_req.c     = r_offset;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    n_w         = r_use_w ? i_chan_weight : FpOne;
                    n_bias      = r_use_b ? i_chan_bias : 32'd0;
                    n_mean      = i_chan_mean;
                    n_var       = i_chan_variance;
                    n_x         = i_sample_value;
                    n_item_last = i_last_sample;
                    n_state     = i_req_type ? CS_FMA : CS_ADDV;
                end
            end
            CS_ADDV: begin
                fpu_req.op = OP_ADD;
                fpu_req.a  = r_var;
                fpu_req.b  = r_eps;
                if (fpu_rsp.done) begin
                    n_tmp   = fpu_rsp.result;
                    n_state = CS_SQRT;
                end
            end
            CS_SQRT: begin
                fpu_req.op = OP_SQRT;
                if (fpu_rsp.done) begin
                    n_tmp   = fpu_rsp.result;
                    n_state = CS_RECIP;
                end
            end
            CS_RECIP: begin
                fpu_req.op = OP_RECIP;
                if (fpu_rsp.done) begin
                    n_tmp   = fpu_rsp.result;
                    n_state = CS_MULW;
                end
            end
            CS_MULW: begin
                fpu_req.op = OP_MUL;
                fpu_req.a  = r_w;
                if (fpu_rsp.done) begin
                    n_scale = fpu_rsp.result;
                    n_state = CS_MULM;
                end
            end
            CS_MULM: begin
                fpu_req.op = OP_MUL;
                fpu_req.a  = r_mean;
                fpu_req.b  = r_scale;
                if (fpu_rsp.done) begin
                    n_tmp   = fpu_rsp.result;
                    n_state = CS_ADDB;
                end
            end
            CS_ADDB: begin
                fpu_req.op = OP_ADD;
                fpu_req.a  = r_bias;
                fpu_req.b  = {~r_tmp[31], r_tmp[30:0]};
                if (fpu_rsp.done) begin
                    n_offset = fpu_rsp.result;
                    n_state  = CS_IDLE;
                end
            end
            CS_FMA: begin
                fpu_req.op = OP_FMA;
                fpu_req.a  = r_scale;
                fpu_req.b  = r_x;
                fpu_req.c  = r_offset;
                if (fpu_rsp.done) begin
                    n_tmp   = fpu_rsp.result;
                    n_state = CS_OUT;
                end
            end
            CS_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_normalized = r_tmp;
                    n_last       = r_item_last;
                    n_state      = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase

        if ((r_state != CS_IDLE) && (r_state != CS_OUT) && !r_issued) begin
            fpu_req.start = 1'b1;
            n_issued      = 1'b1;
        end
        if (fpu_rsp.done) begin
            n_issued = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CS_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_scale     <= 32'd0;
            r_offset    <= 32'd0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_out_valid <= n_out_valid;
            r_scale     <= n_scale;
            r_offset    <= n_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        r_normalized <= n_normalized;
        r_last       <= n_last;
        r_w          <= n_w;
        r_bias       <= n_bias;
        r_mean       <= n_mean;
        r_var        <= n_var;
        r_x          <= n_x;
        r_item_last  <= n_item_last;
        r_tmp        <= n_tmp;
    end

    assign o_in_stall   = (r_state != CS_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_normalized = r_normalized;
    assign o_last       = r_last;

    `BNIF_ASSERT_IMP(a_no_done_when_idle, r_state == CS_IDLE, !fpu_rsp.done,
        "shared unit finished with no operation pending")
    `BNIF_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, r_state != CS_IDLE,
        "accepted beat did not start work")
    `BNIF_ASSERT_IMP(a_result_from_out, $rose(o_out_valid), $past(r_state) == CS_OUT,
        "result beat appeared outside the output step")

endmodule

`default_nettype wire

[sim/batch_norm_inference_fp32_core_tb.sv]
`default_nettype none

module batch_norm_inference_fp32_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bnif_pkg::*;

    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 400;
    localparam logic [31:0] PosInf = 32'h7F80_0000;
    localparam logic [31:0] CanonNan = 32'h7FC0_0000;
    localparam logic [31:0] OneF = 32'h3F80_0000;

    typedef struct {
        bit          req;
        bit [31:0]   weight;
        bit [31:0]   bias;
        bit [31:0]   mean;
        bit [31:0]   variance;
        bit [31:0]   sample;
        bit          last;
        bit          typed;
        bit [31:0]   typed_val;
    } t_beat;

    typedef struct {
        bit [31:0] value;
        bit        last;
    } t_norm;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [31:0] i_chan_weight;
    logic [31:0] i_chan_bias;
    logic [31:0] i_chan_mean;
    logic [31:0] i_chan_variance;
    logic [31:0] i_sample_value;
    logic        i_last_sample;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_normalized;
    logic        o_last;

    batch_norm_inference_fp32_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_req_type(i_req_type),
        .i_chan_weight(i_chan_weight),
        .i_chan_bias(i_chan_bias),
        .i_chan_mean(i_chan_mean),
        .i_chan_variance(i_chan_variance),
        .i_sample_value(i_sample_value),
        .i_last_sample(i_last_sample),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_normalized(o_normalized),
        .o_last(o_last)
    );

    bit [31:0] eps_reg;
    bit        weight_en;
    bit        bias_en;
    bit [31:0] scale_reg;
    bit [31:0] offset_reg;
    t_norm     pending_norms[$];
    int        error_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_request;
    int        hold_left;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic bit f_nan(bit [31:0] x);
        return x[30:0] > PosInf[30:0];
    endfunction

    function automatic bit f_inf(bit [31:0] x);
        return x[30:0] == PosInf[30:0];
    endfunction

    function automatic bit f_zero(bit [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic int top_bit(longint unsigned x);
        int p;
        p = 0;
        for (int i = 63; i >= 0; i--) begin
            if (x[i]) begin
                p = i;
                break;
            end
        end
        return p;
    endfunction

    function automatic void split_fp(input bit [31:0] x, output int e,
                                     output longint unsigned m);
        longint unsigned frac;
        int p;
        frac = 64'(x[22:0]);
        if (x[30:23] == 8'd0) begin
            p = top_bit(frac);
            m = frac << (23 - p);
            e = -149 - (23 - p);
        end else begin
            m = frac | 64'h80_0000;
            e = int'(x[30:23]) - 150;
        end
    endfunction

    function automatic bit [31:0] round_fp(bit s, int e, longint unsigned m, bit sticky);
        int p;
        int ee;
        int q;
        int sh;
        longint unsigned kept;
        longint unsigned rem;
        longint unsigned half;
        bit [31:0] bits;
        p = top_bit(m);
        m = m << (62 - p);
        e = e - (62 - p);
        ee = e + 62;
        if (ee > 127) return {s, PosInf[30:0]};
        q = (ee >= -126) ? ee - 23 : -149;
        sh = q - e;
        if (sh >= 64) return {s, 31'd0};
        kept = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && (sticky || kept[0]))) kept++;
        bits = (ee >= -126) ? (32'(ee + 126) << 23) + 32'(kept) : 32'(kept);
        if (bits >= PosInf) bits = PosInf;
        return {s, bits[30:0]};
    endfunction

    function automatic bit [31:0] exact_sum(bit sa, int ea, longint unsigned ma,
                                            bit sb, int eb, longint unsigned mb);
        int pa;
        int pb;
        int d;
        bit ts;
        int te;
        longint unsigned tm;
        longint unsigned low;
        longint unsigned r;
        bit sticky;
        pa = top_bit(ma);
        pb = top_bit(mb);
        ma = ma << (60 - pa);
        ea = ea - (60 - pa);
        mb = mb << (60 - pb);
        eb = eb - (60 - pb);
        if (eb > ea || (eb == ea && mb > ma)) begin
            ts = sa; sa = sb; sb = ts;
            te = ea; ea = eb; eb = te;
            tm = ma; ma = mb; mb = tm;
        end
        d = ea - eb;
        if (d >= 63) begin
            low = 0;
            sticky = 1'b1;
        end else begin
            low = mb >> d;
            sticky = (mb & ((64'd1 << d) - 64'd1)) != 0;
        end
        if (sa == sb) begin
            r = ma + low;
        end else begin
            r = ma - low;
            if (sticky) r = r - 1;
            if (r == 0 && !sticky) return 32'd0;
        end
        return round_fp(sa, ea, r, sticky);
    endfunction

    function automatic bit [31:0] fadd(bit [31:0] a, bit [31:0] b);
        int ea;
        int eb;
        longint unsigned ma;
        longint unsigned mb;
        if (f_nan(a) || f_nan(b)) return CanonNan;
        if (f_inf(a) && f_inf(b)) return (a[31] == b[31]) ? a : CanonNan;
        if (f_inf(a)) return a;
        if (f_inf(b)) return b;
        if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'd0};
        if (f_zero(a)) return b;
        if (f_zero(b)) return a;
        split_fp(a, ea, ma);
        split_fp(b, eb, mb);
        return exact_sum(a[31], ea, ma, b[31], eb, mb);
    endfunction

    function automatic bit [31:0] fmul(bit [31:0] a, bit [31:0] b);
        bit s;
        int ea;
        int eb;
        longint unsigned ma;
        longint unsigned mb;
        s = a[31] ^ b[31];
        if (f_nan(a) || f_nan(b)) return CanonNan;
        if (f_inf(a) || f_inf(b))
            return (f_zero(a) || f_zero(b)) ? CanonNan : {s, PosInf[30:0]};
        if (f_zero(a) || f_zero(b)) return {s, 31'd0};
        split_fp(a, ea, ma);
        split_fp(b, eb, mb);
        return round_fp(s, ea + eb, ma * mb, 1'b0);
    endfunction

    function automatic bit [31:0] fdiv(bit [31:0] a, bit [31:0] b);
        bit s;
        int ea;
        int eb;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned num;
        s = a[31] ^ b[31];
        if (f_nan(a) || f_nan(b)) return CanonNan;
        if (f_inf(a)) return f_inf(b) ? CanonNan : {s, PosInf[30:0]};
        if (f_inf(b)) return {s, 31'd0};
        if (f_zero(b)) return f_zero(a) ? CanonNan : {s, PosInf[30:0]};
        if (f_zero(a)) return {s, 31'd0};
        split_fp(a, ea, ma);
        split_fp(b, eb, mb);
        num = ma << 40;
        return round_fp(s, ea - eb - 40, num / mb, (num % mb) != 0);
    endfunction

    function automatic bit [31:0] fsqrt(bit [31:0] a);
        int e;
        longint unsigned m;
        longint unsigned v;
        longint unsigned root;
        longint unsigned bitv;
        if (f_nan(a)) return CanonNan;
        if (f_zero(a)) return a;
        if (a[31]) return CanonNan;
        if (f_inf(a)) return a;
        split_fp(a, e, m);
        if (e[0]) begin
            m = m << 1;
            e = e - 1;
        end
        v = m << 38;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return round_fp(1'b0, (e - 38) / 2, root, v != 0);
    endfunction

    function automatic bit [31:0] ffma(bit [31:0] a, bit [31:0] b, bit [31:0] c);
        bit ps;
        int ea;
        int eb;
        int ec;
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned mc;
        ps = a[31] ^ b[31];
        if (f_nan(a) || f_nan(b) || f_nan(c)) return CanonNan;
        if (f_inf(a) || f_inf(b)) begin
            if (f_zero(a) || f_zero(b)) return CanonNan;
            if (f_inf(c) && c[31] != ps) return CanonNan;
            return {ps, PosInf[30:0]};
        end
        if (f_inf(c)) return c;
        if (f_zero(a) || f_zero(b)) begin
            if (f_zero(c)) return {ps & c[31], 31'd0};
            return c;
        end
        split_fp(a, ea, ma);
        split_fp(b, eb, mb);
        if (f_zero(c)) return round_fp(ps, ea + eb, ma * mb, 1'b0);
        split_fp(c, ec, mc);
        return exact_sum(ps, ea + eb, ma * mb, c[31], ec, mc);
    endfunction

    // Updates the channel state or queues the expected normalized beat.
    task automatic predict_norm(t_beat b);
        bit [31:0] w;
        bit [31:0] bs;
        bit [31:0] inv;
        t_norm n;
        if (!b.req) begin
            w = weight_en ? b.weight : OneF;
            bs = bias_en ? b.bias : 32'd0;
            inv = fdiv(OneF, fsqrt(fadd(b.variance, eps_reg)));
            scale_reg = fmul(w, inv);
            offset_reg = fadd(bs, fmul(b.mean, scale_reg) ^ 32'h8000_0000);
        end else begin
            n.value = ffma(scale_reg, b.sample, offset_reg);
            n.last = b.last;
            if (b.typed) n.value = b.typed_val;
            pending_norms.push_back(n);
        end
    endtask

    function automatic bit [31:0] rand_fp();
        bit [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: r = {r[31], 31'd0};
            1: r = {r[31], 8'd0, r[22:0]};
            2: r = {r[31], PosInf[30:0]};
            3: r = {r[31], 8'hFF, r[22:0] | 23'd1};
            4, 5: r = {r[31], 8'($urandom_range(100, 154)), r[22:0]};
            6: r = r;
            default: r = {r[31], 8'($urandom_range(124, 130)), r[22:0]};
        endcase
        return r;
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        b.req = ($urandom_range(0, 99) >= 12);
        b.weight = rand_fp();
        b.bias = rand_fp();
        b.mean = rand_fp();
        if ($urandom_range(0, 3) == 0) begin
            b.variance = rand_fp();
        end else begin
            b.variance = {1'b0, 8'($urandom_range(90, 160)), 23'($urandom)};
        end
        b.sample = rand_fp();
        b.last = 1'($urandom_range(0, 1));
        b.typed = 1'b0;
        b.typed_val = 32'd0;
        return b;
    endfunction

    task automatic write_reg(t_cfg_idx idx, bit [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        case (idx)
            CFG_EPSILON: eps_reg = data;
            CFG_USE_WEIGHT: weight_en = data[0];
            default: bias_en = data[0];
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic send_beat(t_beat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_req_type = b.req;
        i_chan_weight = b.weight;
        i_chan_bias = b.bias;
        i_chan_mean = b.mean;
        i_chan_variance = b.variance;
        i_sample_value = b.sample;
        i_last_sample = b.last;
        do @(posedge i_clk); while (o_in_stall);
        predict_norm(b);
    endtask

    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_norms.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_norm n;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_norms.size() == 0) begin
                $display("%0t: unexpected beat normalized %h last %b",
                         $time, o_normalized, o_last);
                error_count++;
            end else begin
                n = pending_norms.pop_front();
                if (o_normalized !== n.value) begin
                    $display("%0t: normalized expected %h actual %h",
                             $time, n.value, o_normalized);
                    error_count++;
                end
                if (o_last !== n.last) begin
                    $display("%0t: last expected %b actual %b", $time, n.last, o_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_beat dir_rows[$];
        bit [31:0] eps_set[6];
        bit [1:0] flag_set[6];
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_EPSILON;
        i_cfg_data = 32'd0;
        i_in_valid = 1'b0;
        i_req_type = 1'b0;
        i_chan_weight = 32'd0;
        i_chan_bias = 32'd0;
        i_chan_mean = 32'd0;
        i_chan_variance = 32'd0;
        i_sample_value = 32'd0;
        i_last_sample = 1'b0;
        error_count = 0;
        cycle_count = 0;
        hold_request = 1'b0;
        hold_left = 0;
        send_idle_pct = 21;
        recv_idle_pct = 81;
        eps_reg = EpsReset;
        weight_en = 1'b1;
        bias_en = 1'b1;
        scale_reg = 32'd0;
        offset_reg = 32'd0;

        // req, weight, bias, mean, variance, sample, last, typed, expected
        dir_rows = '{
            '{1, 0, 0, 0, 0, OneF, 0, 1, 32'h0000_0000},
            '{1, 0, 0, 0, 0, PosInf, 1, 1, CanonNan},
            '{1, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, CanonNan},
            '{1, 0, 0, 0, 0, 32'hBF80_0000, 1, 1, 32'h0000_0000},
            '{0, OneF, 0, 0, OneF, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 32'h4000_0000, 0, 0, 0},
            '{0, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h7F7F_FFFF, 0, 1, 0, 0},
            '{1, 0, 0, 0, 0, 32'h7F7F_FFFF, 1, 0, 0},
            '{1, 0, 0, 0, 0, 32'h8000_0001, 0, 0, 0},
            '{0, OneF, OneF, 0, 32'hBF80_0000, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, OneF, 0, 1, CanonNan},
            '{0, OneF, OneF, 0, PosInf, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 32'h4040_0000, 1, 1, OneF},
            '{0, 32'h8000_0000, 0, PosInf, OneF, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 32'h0000_0000, 0, 0, 0},
            '{0, 32'h4000_0000, 32'hC000_0000, 32'h3F00_0000, 32'h0000_0001, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 32'h8000_0001, 0, 0, 0},
            '{1, 0, 0, 0, 0, 32'hFF80_0000, 1, 0, 0},
            '{0, OneF, OneF, OneF, 32'h0000_0000, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, 32'h3F80_0000, 0, 0, 0},
            '{0, PosInf, PosInf, OneF, OneF, 0, 0, 0, 0},
            '{1, 0, 0, 0, 0, OneF, 1, 1, CanonNan}
        };

        eps_set = '{32'd0, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'h0000_0001,
                    32'h8000_0000, EpsReset};
        flag_set = '{2'b11, 2'b00, 2'b10, 2'b01, 2'b11, 2'b00};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) send_beat(dir_rows[i]);
        drain_block();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_EPSILON, eps_set[ph]);
            write_reg(CFG_USE_WEIGHT, 32'(flag_set[ph][1]));
            write_reg(CFG_USE_BIAS, 32'(flag_set[ph][0]));
            case (ph % 3)
                0: begin send_idle_pct = 21; recv_idle_pct = 81; end
                1: begin send_idle_pct = 81; recv_idle_pct = 21; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (ph == 2) hold_request = 1'b1;
            for (int k = 0; k < 205; k++) send_beat(rand_beat());
            drain_block();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/bnif_pkg.sv
src/bnif_fpu.sv
src/batch_norm_inference_fp32_core.sv
sim/batch_norm_inference_fp32_core_tb.sv
